// ----- sv/plctb_pkg.sv -----
// shared types and constants of the plc timer bank
package plctb_pkg;

    localparam int unsigned MODE_W  = 3;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned TIME_W  = 32;

    // timer modes, codes above impulse are invalid
    typedef enum logic [MODE_W-1:0] {
        MODE_ON_DELAY  = 3'd0,
        MODE_OFF_DELAY = 3'd1,
        MODE_FLASHER   = 3'd2,
        MODE_CLK_PULSE = 3'd3,
        MODE_IMPULSE   = 3'd4
    } t_mode;

    // per-timer state
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic              phase_flag;
    } t_tmr_state;

endpackage

// ----- sv/plctb_eval.sv -----
// next-state and output logic of one timer access
module plctb_eval (
    input  logic [plctb_pkg::MODE_W-1:0] i_mode,
    input  logic                         i_level,
    input  logic [plctb_pkg::TIME_W-1:0] i_delay_us,
    input  logic [plctb_pkg::TIME_W-1:0] i_now_us,
    input  plctb_pkg::t_tmr_state        i_cur,
    output plctb_pkg::t_tmr_state        o_next,
    output logic                         o_write,
    output logic                         o_timer_out
);
    import plctb_pkg::*;

    logic [TIME_W-1:0] deadline;
    logic              expired;

    // deadline wraps at 32 bits, also the advanced start time
    assign deadline = i_cur.start_time + i_delay_us;
    assign expired  = i_now_us >= deadline;

    always_comb begin
        o_next      = i_cur;
        o_write     = 1'b1;
        o_timer_out = 1'b0;
        unique case (t_mode'(i_mode))
            MODE_ON_DELAY: begin
                if (!i_level) begin
                    o_next.start_time = i_now_us;
                end else begin
                    o_timer_out = expired;
                end
            end
            MODE_OFF_DELAY: begin
                if (i_level) begin
                    o_next.start_time = i_now_us;
                    o_timer_out       = 1'b1;
                end else begin
                    o_timer_out = !expired;
                end
            end
            MODE_FLASHER: begin
                if (!i_level) begin
                    o_next.start_time = i_now_us;
                    o_next.phase_flag = 1'b0;
                end else if (expired) begin
                    o_next.phase_flag = !i_cur.phase_flag;
                    o_next.start_time = deadline;
                    o_timer_out       = i_cur.phase_flag;
                end else begin
                    o_timer_out = !i_cur.phase_flag;
                end
            end
            MODE_CLK_PULSE: begin
                if (!i_level) begin
                    o_next.start_time = i_now_us;
                    o_next.phase_flag = 1'b0;
                end else if (!i_cur.phase_flag) begin
                    o_next.phase_flag = 1'b1;
                    o_timer_out       = 1'b1;
                end else if (expired) begin
                    o_next.start_time = deadline;
                    o_timer_out       = 1'b1;
                end
            end
            MODE_IMPULSE: begin
                if (!i_level && !i_cur.phase_flag) begin
                    o_next.start_time = i_now_us;
                end else begin
                    // flag set now or already running
                    o_next.phase_flag = !expired;
                    o_timer_out       = !expired;
                end
            end
            default: begin
                o_write = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/plc_timer_bank.sv -----
// plc timer bank top level: input register, timer state array, result register
// result strobe o_done comes from the result register, behind the input register
// throughput: one item per cycle, busy is never raised
// the state written by one item is seen by the item right behind it
// reset (synchronous, active low) clears all start times and phase flags
// and the pipeline valid bits; results cannot be stalled by the receiver
module plc_timer_bank #(
    parameter int unsigned TIMER_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [plctb_pkg::MODE_W-1:0]  i_mode,
    input  logic [plctb_pkg::INDEX_W-1:0] i_timer_index,
    input  logic                          i_level,
    input  logic [plctb_pkg::TIME_W-1:0]  i_delay_us,
    input  logic [plctb_pkg::TIME_W-1:0]  i_now_us,
    output logic                          o_done,
    output logic                          o_timer_out
);
    import plctb_pkg::*;

    // only indexes below 2**INDEX_W can be addressed, so storage stops there
    localparam int unsigned DEPTH = (TIMER_COUNT < (1 << INDEX_W)) ?
                                    TIMER_COUNT : (1 << INDEX_W);
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [INDEX_W:0] INDEX_LIMIT = (INDEX_W + 1)'(DEPTH);

    // input stage
    logic                  r_v1;
    logic [MODE_W-1:0]     r_mode;
    logic [INDEX_W-1:0]    r_idx;
    logic                  r_level;
    logic [TIME_W-1:0]     r_delay;
    logic [TIME_W-1:0]     r_now;

    // timer state array, reset to zero
    t_tmr_state            r_state [DEPTH];

    // result stage
    logic                  r_done;
    logic                  r_out;

    logic                  in_range;
    logic [ADDR_W-1:0]     addr;
    t_tmr_state            cur;
    t_tmr_state            n_state;
    logic                  eval_write;
    logic                  eval_out;
    logic                  n_out;

    // no back-pressure: every start is taken
    assign busy = 1'b0;

    // out-of-range index gives low and leaves the bank alone
    assign in_range = {1'b0, r_idx} < INDEX_LIMIT;
    assign addr     = ADDR_W'(r_idx);
    assign cur      = in_range ? r_state[addr] : '0;

    plctb_eval u_eval (
        .i_mode      (r_mode),
        .i_level     (r_level),
        .i_delay_us  (r_delay),
        .i_now_us    (r_now),
        .i_cur       (cur),
        .o_next      (n_state),
        .o_write     (eval_write),
        .o_timer_out (eval_out)
    );

    assign n_out = in_range & eval_out;

    // pipeline control and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_state[i] <= '0;
            end
        end else begin
            r_v1   <= start & !busy;
            r_done <= r_v1;
            if (r_v1 && in_range && eval_write) begin
                r_state[addr] <= n_state;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode  <= i_mode;
            r_idx   <= i_timer_index;
            r_level <= i_level;
            r_delay <= i_delay_us;
            r_now   <= i_now_us;
        end
        r_out <= n_out;
    end

    // output bit is low outside the strobe cycle
    assign o_done      = r_done;
    assign o_timer_out = r_done & r_out;

endmodule

// ----- sv/plctb_chk.sv -----
// port-level checker for the plc timer bank, bound to the top level
module plctb_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [plctb_pkg::MODE_W-1:0]  i_mode,
    input logic [plctb_pkg::INDEX_W-1:0] i_timer_index,
    input logic                          i_level,
    input logic [plctb_pkg::TIME_W-1:0]  i_delay_us,
    input logic [plctb_pkg::TIME_W-1:0]  i_now_us,
    input logic                          o_done,
    input logic                          o_timer_out
);
    import plctb_pkg::*;

    // every accepted item is followed by one result strobe
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("no result strobe for accepted item");

    // no strobe without an accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without accepted item");

    // invalid mode gives low
    a_invalid_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode > MODE_W'(MODE_IMPULSE)) |-> ##2 !o_timer_out)
        else $error("invalid mode gave high output");

    // on-delay with low input gives low
    a_ton_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_W'(MODE_ON_DELAY) && !i_level)
        |-> ##2 !o_timer_out)
        else $error("on-delay with low input gave high output");

    // output bit only during a strobe
    a_out_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_timer_out |-> o_done)
        else $error("timer output high outside result strobe");

endmodule

bind plc_timer_bank plctb_chk u_plctb_chk (.*);

// ----- sim/tb.sv -----
// self-checking testbench of the plc timer bank: random and directed timer accesses
`timescale 1ns / 100ps

module tb;

    import plctb_pkg::*;

    localparam int unsigned TIMER_COUNT = 16;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int unsigned DRAIN_CYCLES = 8;    // extra wait after the last result strobe

    // mode codes above impulse, all give a low output
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    // one timer access as it goes over the start interface
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] idx;
        logic               level;
        logic [TIME_W-1:0]  delay_us;
        logic [TIME_W-1:0]  now_us;
    } t_timer_access;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [MODE_W-1:0]   i_mode = '0;
    logic [INDEX_W-1:0]  i_timer_index = '0;
    logic                i_level = 1'b0;
    logic [TIME_W-1:0]   i_delay_us = '0;
    logic [TIME_W-1:0]   i_now_us = '0;
    logic                o_done;
    logic                o_timer_out;

    // accesses waiting to be driven, and timer outputs waiting to come back
    t_timer_access       access_backlog[$];
    logic                timer_out_due[$];

    // shadow copy of the bank state, updated in acceptance order
    logic [TIME_W-1:0]   shadow_start[TIMER_COUNT];
    logic                shadow_flag[TIMER_COUNT];

    int unsigned         mismatch_cnt = 0;
    int unsigned         accepted_cnt = 0;
    int unsigned         access_total = 0;

    plc_timer_bank #(
        .TIMER_COUNT(TIMER_COUNT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_timer_index(i_timer_index),
        .i_level(i_level),
        .i_delay_us(i_delay_us),
        .i_now_us(i_now_us),
        .o_done(o_done),
        .o_timer_out(o_timer_out)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    // deadline is start + delay modulo 2^32, compared unsigned with no wrap fix
    function automatic bit deadline_passed(logic [TIME_W-1:0] t0, logic [TIME_W-1:0] dly,
                                           logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] deadline;
        deadline = t0 + dly;
        return now >= deadline;
    endfunction

    // timer output for one access; updates the shadow state as the bank would
    function automatic logic timer_response(t_timer_access acc);
        logic [TIME_W-1:0] t0;
        logic              fl;
        logic              res;
        res = 1'b0;
        if (acc.idx < TIMER_COUNT) begin
            t0 = shadow_start[acc.idx];
            fl = shadow_flag[acc.idx];
            case (acc.mode)
                MODE_ON_DELAY: begin
                    if (!acc.level) begin
                        t0 = acc.now_us;
                    end else begin
                        res = deadline_passed(t0, acc.delay_us, acc.now_us);
                    end
                end
                MODE_OFF_DELAY: begin
                    if (acc.level) begin
                        t0 = acc.now_us;
                        res = 1'b1;
                    end else begin
                        res = !deadline_passed(t0, acc.delay_us, acc.now_us);
                    end
                end
                MODE_FLASHER: begin
                    if (!acc.level) begin
                        t0 = acc.now_us;
                        fl = 1'b0;
                    end else if (deadline_passed(t0, acc.delay_us, acc.now_us)) begin
                        // half period over: flip phase, step start by one half period
                        res = fl;
                        fl = !fl;
                        t0 = t0 + acc.delay_us;
                    end else begin
                        res = !fl;
                    end
                end
                MODE_CLK_PULSE: begin
                    if (!acc.level) begin
                        t0 = acc.now_us;
                        fl = 1'b0;
                    end else if (!fl) begin
                        // first high sample always pulses
                        fl = 1'b1;
                        res = 1'b1;
                    end else if (deadline_passed(t0, acc.delay_us, acc.now_us)) begin
                        t0 = t0 + acc.delay_us;
                        res = 1'b1;
                    end
                end
                MODE_IMPULSE: begin
                    if (acc.level && !fl) begin
                        fl = 1'b1;
                    end
                    if (!acc.level && !fl) begin
                        t0 = acc.now_us;
                    end
                    if (fl) begin
                        if (deadline_passed(t0, acc.delay_us, acc.now_us)) begin
                            fl = 1'b0;
                        end else begin
                            res = 1'b1;
                        end
                    end
                end
                default: begin
                    res = 1'b0;
                end
            endcase
            shadow_start[acc.idx] = t0;
            shadow_flag[acc.idx] = fl;
        end
        return res;
    endfunction

    function automatic void queue_access(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                         logic level, logic [TIME_W-1:0] dly,
                                         logic [TIME_W-1:0] now);
        t_timer_access acc;
        acc.mode = mode;
        acc.idx = idx;
        acc.level = level;
        acc.delay_us = dly;
        acc.now_us = now;
        access_backlog.push_back(acc);
        access_total++;
    endfunction

    // mostly short delays so expiry is hit often, some long and full range ones
    function automatic logic [TIME_W-1:0] pick_delay();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return $urandom_range(0, 60);
        end else if (roll < 95) begin
            return $urandom_range(0, 1000);
        end
        return $urandom;
    endfunction

    // gap before the next access: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // driver: presents the backlog on the start interface, predicts on acceptance
    t_timer_access shown_access;
    int unsigned   gap_left = 0;
    int unsigned   burst_left = 0;

    always @(posedge i_clk) begin : access_driver
        logic present;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            present = start;
            if (start && !busy) begin
                timer_out_due.push_back(timer_response(shown_access));
                accepted_cnt++;
                present = 1'b0;
                // now and then a back-to-back stretch with no gaps at all
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else if ($urandom_range(0, 99) < 3) begin
                    burst_left = $urandom_range(20, 60);
                    gap_left = 0;
                end else begin
                    gap_left = pick_gap();
                end
            end
            if (!present) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (access_backlog.size() > 0) begin
                    shown_access = access_backlog.pop_front();
                    i_mode <= shown_access.mode;
                    i_timer_index <= shown_access.idx;
                    i_level <= shown_access.level;
                    i_delay_us <= shown_access.delay_us;
                    i_now_us <= shown_access.now_us;
                    present = 1'b1;
                end
            end
            start <= present;
        end
    end

    // monitor: every result strobe is matched against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        logic want;
        if (i_rst_n && o_done) begin
            if (timer_out_due.size() == 0) begin
                report_mismatch($sformatf("result %0b with no item outstanding", o_timer_out));
            end else begin
                want = timer_out_due.pop_front();
                if (o_timer_out !== want) begin
                    report_mismatch($sformatf("timer_out got %b want %b", o_timer_out, want));
                end
            end
        end
    end

    // watchdog: too long with neither an accepted item nor a result
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin : stall_watchdog
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles", STALL_LIMIT);
                $display("FAIL plc_timer_bank");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // per-timer context of the well-formed random sequences
    logic [MODE_W-1:0]  seq_mode[TIMER_COUNT];
    logic [TIME_W-1:0]  seq_delay[TIMER_COUNT];
    logic               seq_level[TIMER_COUNT];

    initial begin : stimulus_and_end
        logic [TIME_W-1:0]  clock_us;
        logic [INDEX_W-1:0] idx;
        int unsigned        roll;

        for (int k = 0; k < TIMER_COUNT; k++) begin
            shadow_start[k] = '0;
            shadow_flag[k] = 1'b0;
            seq_mode[k] = MODE_W'($urandom_range(0, 4));
            seq_delay[k] = pick_delay();
            seq_level[k] = 1'($urandom_range(0, 1));
        end

        // on-delay: load, not yet, exactly at the deadline, zero delay
        queue_access(MODE_ON_DELAY, 4'd0, 1'b0, 32'd50, 32'd100);
        queue_access(MODE_ON_DELAY, 4'd0, 1'b1, 32'd50, 32'd120);
        queue_access(MODE_ON_DELAY, 4'd0, 1'b1, 32'd50, 32'd150);
        queue_access(MODE_ON_DELAY, 4'd0, 1'b1, 32'd0, 32'd100);
        // off-delay: hold high, one before the deadline, at the deadline
        queue_access(MODE_OFF_DELAY, 4'd1, 1'b1, 32'd10, 32'd1000);
        queue_access(MODE_OFF_DELAY, 4'd1, 1'b0, 32'd10, 32'd1009);
        queue_access(MODE_OFF_DELAY, 4'd1, 1'b0, 32'd10, 32'd1010);
        // flasher: both phases and both flips
        queue_access(MODE_FLASHER, 4'd2, 1'b0, 32'd5, 32'd0);
        queue_access(MODE_FLASHER, 4'd2, 1'b1, 32'd5, 32'd3);
        queue_access(MODE_FLASHER, 4'd2, 1'b1, 32'd5, 32'd5);
        queue_access(MODE_FLASHER, 4'd2, 1'b1, 32'd5, 32'd7);
        queue_access(MODE_FLASHER, 4'd2, 1'b1, 32'd5, 32'd10);
        // clock pulse: first high sample, wait, pulse on expiry
        queue_access(MODE_CLK_PULSE, 4'd3, 1'b0, 32'd10, 32'd200);
        queue_access(MODE_CLK_PULSE, 4'd3, 1'b1, 32'd10, 32'd201);
        queue_access(MODE_CLK_PULSE, 4'd3, 1'b1, 32'd10, 32'd205);
        queue_access(MODE_CLK_PULSE, 4'd3, 1'b1, 32'd10, 32'd210);
        // impulse: trigger, input gone but pulse holds, pulse ends
        queue_access(MODE_IMPULSE, 4'd4, 1'b0, 32'd20, 32'd300);
        queue_access(MODE_IMPULSE, 4'd4, 1'b1, 32'd20, 32'd305);
        queue_access(MODE_IMPULSE, 4'd4, 1'b0, 32'd20, 32'd319);
        queue_access(MODE_IMPULSE, 4'd4, 1'b0, 32'd20, 32'd320);
        // invalid modes at the field extremes
        queue_access(MODE_RSVD5, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(MODE_RSVD6, 4'd15, 1'b0, 32'h0, 32'h0);
        queue_access(MODE_RSVD7, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'h0);
        // time wrap: deadline wraps past zero and counts as expired at once
        queue_access(MODE_ON_DELAY, 4'd14, 1'b0, 32'h20, 32'hFFFF_FFF0);
        queue_access(MODE_ON_DELAY, 4'd14, 1'b1, 32'h20, 32'hFFFF_FFF8);

        clock_us = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 12) begin
                // noise: every field free
                queue_access(MODE_W'($urandom_range(0, 7)), INDEX_W'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)), $urandom, $urandom);
            end else begin
                // mostly a handful of timers so each one sees a coherent sequence
                if ($urandom_range(0, 99) < 60) begin
                    idx = INDEX_W'($urandom_range(0, 3));
                end else begin
                    idx = INDEX_W'($urandom_range(0, 15));
                end
                roll = $urandom_range(0, 99);
                if (roll < 1) begin
                    seq_mode[idx] = MODE_W'($urandom_range(0, 7));
                end else if (roll < 5) begin
                    seq_mode[idx] = MODE_W'($urandom_range(0, 4));
                end
                if ($urandom_range(0, 99) < 3) begin
                    seq_delay[idx] = pick_delay();
                end
                if ($urandom_range(0, 99) < 20) begin
                    seq_level[idx] = !seq_level[idx];
                end
                clock_us = clock_us + $urandom_range(0, 12);
                roll = $urandom_range(0, 999);
                if (roll < 5) begin
                    clock_us = $urandom;
                end else if (roll < 13) begin
                    // park the clock just short of the wrap
                    clock_us = 32'hFFFF_FF00 + $urandom_range(0, 200);
                end
                queue_access(seq_mode[idx], idx, seq_level[idx], seq_delay[idx], clock_us);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled on the falling edge so the clocked blocks have settled
        do begin
            @(negedge i_clk);
        end while (accepted_cnt < access_total || timer_out_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (timer_out_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never came", timer_out_due.size()));
        end

        if (mismatch_cnt == 0) begin
            $display("PASS plc_timer_bank");
        end else begin
            $display("FAIL plc_timer_bank");
        end
        $finish;
    end

endmodule
